// ===== design/thermistor_temp_ema_core_defines.svh =====
// assertion helpers for the thermistor core
`ifndef THERMISTOR_TEMP_EMA_CORE_DEFINES_SVH
`define THERMISTOR_TEMP_EMA_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tte_pkg.sv =====
package tte_pkg;

    localparam int OVERSAMPLE_N_DEF  = 8;
    localparam int NOMINAL_CELSIUS   = 25;
    localparam int FULL_SCALE_COUNTS = 1650;

    localparam int T0C       = NOMINAL_CELSIUS * 100 + 27315;
    localparam int T0C_X144  = T0C * 144;
    localparam int LN2_Q20   = 726817;
    localparam int FRAC_BITS = 20;
    localparam int MANT_W    = 31;
    localparam int X_CAP     = 40000;
    localparam int K_TO_F    = 7355;
    localparam int ALPHA_ONE = 256;

    localparam logic signed [14:0] TEMP_LO = 15'sh4000;
    localparam logic signed [14:0] TEMP_HI = 15'sh3fff;

    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_SERIES  = 3'd0,
        REG_NOMINAL = 3'd1,
        REG_BETA    = 3'd2,
        REG_ALPHA   = 3'd3,
        REG_PIT_OFS = 3'd4,
        REG_MEAT_OFS = 3'd5,
        REG_VMIN    = 3'd6,
        REG_VMAX    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [19:0] series_ohms;
        logic        [19:0] nominal_ohms;
        logic        [13:0] beta_kelvin;
        logic        [8:0]  alpha_q8;
        logic signed [11:0] pit_offset;
        logic signed [11:0] meat_offset;
        logic signed [14:0] valid_min;
        logic signed [14:0] valid_max;
    } cfg_t;

    typedef struct packed {
        logic               channel;
        logic signed [14:0] temp_f;
        logic               in_range;
        logic               fault;
    } res_t;

endpackage

// ===== design/thermistor_temp_ema_core.sv =====
// port group   | dir | purpose
// s_t*         | in  | adc word: tuser channel, tdata sample
// m_t*         | out | result word: tuser channel, tdata temp/in_range/fault
// p*           | in  | register access, 8 registers at 4-byte stride
// a word that does not close a group is added to its channel's sum; a faulted group skips the computation
// a closing word holds the input while the result is computed on the shared multiplier:
// two log passes (normalize, 20 squarings), a 16-step divide, ema multiplies
// s_tready stays low while a group is computed and while its result waits
// reset clears accumulators, ema state and registers to their defaults
`include "thermistor_temp_ema_core_defines.svh"
module thermistor_temp_ema_core
    import tte_pkg::*;
#(
    parameter int OVERSAMPLE_N = OVERSAMPLE_N_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // sample[11:0], zero pad
    input  logic                  s_tuser,   // channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // temp_f[14:0], in_range, fault, zero pad
    output logic                  m_tuser,   // channel_out
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t  cfg;
    res_t  res;
    logic  res_valid;
    logic  res_ready;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        m_user_reg;

    tte_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tte_engine #(
        .OVERSAMPLE_N (OVERSAMPLE_N)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_channel (s_tuser),
        .in_sample  (s_tdata[11:0]),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

    assign res_ready = !m_valid_reg || m_tready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= {7'd0, res.fault, res.in_range, res.temp_f};
            m_user_reg <= res.channel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `TTE_ASSERT_NOW(a_fault_not_in_range, m_tvalid && m_tdata[16], !m_tdata[15],
        "faulted word flagged in range")
    `TTE_ASSERT_NOW(a_busy_blocks_input, res_valid, !s_tready,
        "input taken while a result is pending")
    `TTE_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, m_tvalid,
        "finished result not presented")

endmodule

// ===== design/tte_mul.sv =====
module tte_mul
    import tte_pkg::*;
(
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    assign prod = 64'(op_a) * 64'(op_b);

endmodule

// ===== design/tte_regs.sv =====
module tte_regs
    import tte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx = reg_idx_t'(paddr[4:2]);
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.series_ohms  <= 20'd10000;
            cfg_reg.nominal_ohms <= 20'd10000;
            cfg_reg.beta_kelvin  <= 14'd3950;
            cfg_reg.alpha_q8     <= 9'd26;
            cfg_reg.pit_offset   <= '0;
            cfg_reg.meat_offset  <= '0;
            cfg_reg.valid_min    <= '0;
            cfg_reg.valid_max    <= 15'sd12000;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_SERIES:   cfg_reg.series_ohms  <= pwdata[19:0];
                REG_NOMINAL:  cfg_reg.nominal_ohms <= pwdata[19:0];
                REG_BETA:     cfg_reg.beta_kelvin  <= pwdata[13:0];
                REG_ALPHA:    cfg_reg.alpha_q8     <= pwdata[8:0];
                REG_PIT_OFS:  cfg_reg.pit_offset   <= pwdata[11:0];
                REG_MEAT_OFS: cfg_reg.meat_offset  <= pwdata[11:0];
                REG_VMIN:     cfg_reg.valid_min    <= pwdata[14:0];
                REG_VMAX:     cfg_reg.valid_max    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SERIES:   prdata = 32'(cfg_reg.series_ohms);
            REG_NOMINAL:  prdata = 32'(cfg_reg.nominal_ohms);
            REG_BETA:     prdata = 32'(cfg_reg.beta_kelvin);
            REG_ALPHA:    prdata = 32'(cfg_reg.alpha_q8);
            REG_PIT_OFS:  prdata = {20'd0, cfg_reg.pit_offset};
            REG_MEAT_OFS: prdata = {20'd0, cfg_reg.meat_offset};
            REG_VMIN:     prdata = {17'd0, cfg_reg.valid_min};
            REG_VMAX:     prdata = {17'd0, cfg_reg.valid_max};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/tte_engine.sv =====
module tte_engine
    import tte_pkg::*;
#(
    parameter int OVERSAMPLE_N = OVERSAMPLE_N_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_channel,
    input  logic [11:0] in_sample,
    output res_t        res,
    output logic        res_valid,
    input  logic        res_ready
);

    localparam int SUM_W = 12 + $clog2(OVERSAMPLE_N);
    localparam int CNT_W = (OVERSAMPLE_N > 1) ? $clog2(OVERSAMPLE_N) : 1;
    localparam int X_W   = 20 + SUM_W;
    localparam int P_W   = $clog2(X_W);
    localparam int LOG_W = P_W + FRAC_BITS;
    localparam logic [SUM_W-1:0] FULL     = SUM_W'(FULL_SCALE_COUNTS * OVERSAMPLE_N);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(OVERSAMPLE_N - 1);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MX    = 13'b0000000000010,
        ST_NORM  = 13'b0000000000100,
        ST_SQ    = 13'b0000000001000,
        ST_LN    = 13'b0000000010000,
        ST_DCALC = 13'b0000000100000,
        ST_NCALC = 13'b0000001000000,
        ST_DCHK  = 13'b0000010000000,
        ST_DIV   = 13'b0000100000000,
        ST_CUR   = 13'b0001000000000,
        ST_EMA1  = 13'b0010000000000,
        ST_EMA2  = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t                    state_reg;
    logic        [SUM_W-1:0]   sum_reg [2];
    logic        [CNT_W-1:0]   cnt_reg [2];
    logic signed [14:0]        smooth_reg [2];
    logic        [1:0]         primed_reg;

    logic                      ch_reg;
    logic        [SUM_W-1:0]   s_reg;
    logic                      fault_reg;
    logic                      second_reg;
    logic        [X_W-1:0]     x_reg;
    logic        [P_W-1:0]     p_reg;
    logic        [MANT_W-1:0]  m_reg;
    logic        [19:0]        frac_reg;
    logic        [4:0]         it_reg;
    logic        [LOG_W-1:0]   loga_reg;
    logic signed [LOG_W:0]     l_reg;
    logic signed [LOG_W:0]     ln_reg;
    logic signed [63:0]        d_reg;
    logic        [63:0]        num_reg;
    logic        [63:0]        den_reg;
    logic        [63:0]        rem_reg;
    logic        [63:0]        dsh_reg;
    logic        [15:0]        q_reg;
    logic signed [16:0]        base_reg;
    logic signed [14:0]        cur_reg;
    logic signed [31:0]        ema_reg;

    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] prod;

    logic [19:0]        ser_eff;
    logic [19:0]        nom_eff;
    logic [8:0]         alpha_eff;
    logic [LOG_W:0]     l_abs;
    logic [SUM_W-1:0]   new_sum;
    logic               new_fault;
    logic [31:0]        sq;
    logic               sq_bit;
    logic [19:0]        frac_next;
    logic [LOG_W-1:0]   log_now;
    logic [63:0]        ln_round;
    logic [LOG_W-1:0]   ln_mag;
    logic [63:0]        b100;
    logic [63:0]        n_val;
    logic [63:0]        d_u;
    logic               div_ge;
    logic [15:0]        q_next;
    logic [15:0]        x_q;
    logic signed [17:0] cur_sum;
    logic signed [14:0] cur_next;
    logic signed [31:0] ema_sum;
    logic signed [14:0] t_out;

    tte_mul u_mul (
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign ser_eff   = (cfg.series_ohms == '0) ? 20'd1 : cfg.series_ohms;
    assign nom_eff   = (cfg.nominal_ohms == '0) ? 20'd1 : cfg.nominal_ohms;
    assign alpha_eff = (cfg.alpha_q8 > 9'(ALPHA_ONE)) ? 9'(ALPHA_ONE) : cfg.alpha_q8;
    assign l_abs     = l_reg[LOG_W] ? (LOG_W+1)'(-l_reg) : (LOG_W+1)'(l_reg);

    always_comb begin
        case (state_reg)
            ST_MX: begin
                op_a = second_reg ? 32'(nom_eff) : 32'(ser_eff);
                op_b = second_reg ? 32'(FULL - s_reg) : 32'(s_reg);
            end
            ST_SQ: begin
                op_a = 32'(m_reg);
                op_b = 32'(m_reg);
            end
            ST_LN: begin
                op_a = 32'(l_abs);
                op_b = 32'(LN2_Q20);
            end
            ST_DCALC: begin
                op_a = 32'(T0C);
                op_b = 32'(ln_reg);
            end
            ST_NCALC: begin
                op_a = 32'(cfg.beta_kelvin);
                op_b = 32'(T0C_X144);
            end
            ST_EMA1: begin
                op_a = 32'(cur_reg);
                op_b = 32'(alpha_eff);
            end
            ST_EMA2: begin
                op_a = 32'(smooth_reg[ch_reg]);
                op_b = 32'(9'(ALPHA_ONE) - alpha_eff);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign new_sum   = sum_reg[in_channel] + SUM_W'(in_sample);
    assign new_fault = (new_sum == '0) || (new_sum >= FULL);

    // one squaring step of the log mantissa
    assign sq        = prod[61:30];
    assign sq_bit    = sq[31];
    assign frac_next = {frac_reg[18:0], sq_bit};
    assign log_now   = {p_reg, frac_next};

    assign ln_round = unsigned'(prod) + 64'(1 << 19);
    assign ln_mag   = ln_round[FRAC_BITS +: LOG_W];

    assign b100  = 64'(cfg.beta_kelvin) * 64'd100;
    assign n_val = unsigned'(prod) << FRAC_BITS;
    assign d_u   = unsigned'(d_reg);

    assign div_ge = rem_reg >= dsh_reg;
    assign q_next = {q_reg[14:0], div_ge};
    assign x_q    = (q_next > 16'(X_CAP)) ? 16'(X_CAP) : q_next;

    assign cur_sum = 18'(base_reg)
                   + 18'(ch_reg ? cfg.meat_offset : cfg.pit_offset);
    always_comb begin
        if (cur_sum < 18'(TEMP_LO)) begin
            cur_next = TEMP_LO;
        end else if (cur_sum > 18'(TEMP_HI)) begin
            cur_next = TEMP_HI;
        end else begin
            cur_next = cur_sum[14:0];
        end
    end

    assign ema_sum = ema_reg + prod[31:0] + 32'sd128;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            smooth_reg[0] <= '0;
            smooth_reg[1] <= '0;
            primed_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        if (cnt_reg[in_channel] == LAST_CNT) begin
                            sum_reg[in_channel] <= '0;
                            cnt_reg[in_channel] <= '0;
                            s_reg      <= new_sum;
                            ch_reg     <= in_channel;
                            fault_reg  <= new_fault;
                            second_reg <= 1'b0;
                            state_reg  <= new_fault ? ST_OUT : ST_MX;
                        end else begin
                            sum_reg[in_channel] <= new_sum;
                            cnt_reg[in_channel] <= cnt_reg[in_channel] + 1'b1;
                        end
                    end
                end
                ST_MX: begin
                    x_reg     <= prod[X_W-1:0];
                    p_reg     <= P_W'(X_W - 1);
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    if (x_reg[X_W-1]) begin
                        m_reg     <= x_reg[X_W-1 -: MANT_W];
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_SQ;
                    end else if (x_reg[X_W-1 -: 8] == '0 && p_reg >= P_W'(8)) begin
                        x_reg <= x_reg << 8;
                        p_reg <= p_reg - P_W'(8);
                    end else begin
                        x_reg <= x_reg << 1;
                        p_reg <= p_reg - 1'b1;
                    end
                end
                ST_SQ: begin
                    m_reg    <= sq_bit ? sq[31:1] : sq[30:0];
                    frac_reg <= frac_next;
                    it_reg   <= it_reg + 1'b1;
                    if (it_reg == 5'(FRAC_BITS - 1)) begin
                        if (!second_reg) begin
                            loga_reg   <= log_now;
                            second_reg <= 1'b1;
                            state_reg  <= ST_MX;
                        end else begin
                            l_reg     <= $signed({1'b0, loga_reg}) - $signed({1'b0, log_now});
                            state_reg <= ST_LN;
                        end
                    end
                end
                ST_LN: begin
                    ln_reg    <= l_reg[LOG_W] ? -$signed({1'b0, ln_mag})
                                              : $signed({1'b0, ln_mag});
                    state_reg <= ST_DCALC;
                end
                ST_DCALC: begin
                    d_reg     <= $signed(b100 << FRAC_BITS) + prod;
                    state_reg <= ST_NCALC;
                end
                ST_NCALC: begin
                    if (d_reg[63] || d_reg == '0) begin
                        base_reg  <= 17'(TEMP_LO);
                        state_reg <= ST_CUR;
                    end else begin
                        num_reg   <= (n_val << 1) + (d_u << 2) + d_u;
                        den_reg   <= (d_u << 3) + (d_u << 1);
                        state_reg <= ST_DCHK;
                    end
                end
                ST_DCHK: begin
                    if (num_reg >= (den_reg << 16)) begin
                        base_reg  <= 17'(X_CAP - K_TO_F);
                        state_reg <= ST_CUR;
                    end else begin
                        rem_reg   <= num_reg;
                        dsh_reg   <= den_reg << 15;
                        q_reg     <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= q_next;
                    dsh_reg <= dsh_reg >> 1;
                    it_reg  <= it_reg + 1'b1;
                    if (it_reg == 5'd15) begin
                        base_reg  <= $signed({1'b0, x_q}) - 17'sd7355;
                        state_reg <= ST_CUR;
                    end
                end
                ST_CUR: begin
                    cur_reg <= cur_next;
                    if (!primed_reg[ch_reg]) begin
                        smooth_reg[ch_reg] <= cur_next;
                        primed_reg[ch_reg] <= 1'b1;
                        state_reg          <= ST_OUT;
                    end else begin
                        state_reg <= ST_EMA1;
                    end
                end
                ST_EMA1: begin
                    ema_reg   <= prod[31:0];
                    state_reg <= ST_EMA2;
                end
                ST_EMA2: begin
                    smooth_reg[ch_reg] <= ema_sum[22:8];
                    state_reg          <= ST_OUT;
                end
                ST_OUT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    assign t_out        = smooth_reg[ch_reg];
    assign res.channel  = ch_reg;
    assign res.temp_f   = t_out;
    assign res.fault    = fault_reg;
    assign res.in_range = !fault_reg && (t_out >= cfg.valid_min) && (t_out <= cfg.valid_max);

endmodule
